// ===== hw/rtl/slk_pkg.sv =====
// ----------------------------------------------------------------------------
// slk_pkg
// Shared types and codes for the sensor UART register link.
// ----------------------------------------------------------------------------
package slk_pkg;

   localparam int GroupDepth = 4;
   localparam int GroupCountWidth = $clog2(GroupDepth + 1);
   localparam int GroupIndexWidth = $clog2(GroupDepth);

   localparam logic [7:0] MaxWriteBytes = 8'd128;

   // request modes
   localparam logic [2:0] ModeStartRead  = 3'd0;
   localparam logic [2:0] ModeStartWrite = 3'd1;
   localparam logic [2:0] ModePayload    = 3'd2;
   localparam logic [2:0] ModeReceived   = 3'd3;
   localparam logic [2:0] ModeTick       = 3'd4;

   // result kinds
   localparam logic [1:0] KindTransmit = 2'd0;
   localparam logic [1:0] KindReadData = 2'd1;
   localparam logic [1:0] KindStatus   = 2'd2;

   // transaction status codes
   localparam logic [2:0] StOk         = 3'd0;
   localparam logic [2:0] StBadRequest = 3'd1;
   localparam logic [2:0] StTimeout    = 3'd2;
   localparam logic [2:0] StWrRejected = 3'd3;
   localparam logic [2:0] StRdRefused  = 3'd4;
   localparam logic [2:0] StBadHeader  = 3'd5;
   localparam logic [2:0] StMismatch   = 3'd6;

   // register indexes
   localparam logic [2:0] CsrTimeoutMs     = 3'd0;
   localparam logic [2:0] CsrStartByte     = 3'd1;
   localparam logic [2:0] CsrReadCommand   = 3'd2;
   localparam logic [2:0] CsrWriteCommand  = 3'd3;
   localparam logic [2:0] CsrReadReplyHdr  = 3'd4;
   localparam logic [2:0] CsrAckReplyHdr   = 3'd5;
   localparam logic [2:0] CsrWriteOkCode   = 3'd6;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] address;
      logic [7:0] count;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [7:0]  start_byte;
      logic [7:0]  read_command;
      logic [7:0]  write_command;
      logic [7:0]  read_reply_header;
      logic [7:0]  ack_reply_header;
      logic [7:0]  write_ok_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic [2:0] status;
      logic [7:0] device_status;
   } res_type;

   typedef struct packed {
      logic                             load;
      logic [GroupCountWidth-1:0]       count;
      res_type [GroupDepth-1:0]         entry;
   } grp_type;

   function automatic res_type mk_byte(input logic [1:0] kind, input logic [7:0] value);
      res_type r;
      r.kind          = kind;
      r.byte_value    = value;
      r.status        = StOk;
      r.device_status = 8'd0;
      return r;
   endfunction

   function automatic res_type mk_status(input logic [2:0] st, input logic [7:0] dev);
      res_type r;
      r.kind          = KindStatus;
      r.byte_value    = 8'd0;
      r.status        = st;
      r.device_status = dev;
      return r;
   endfunction

endpackage

// ===== hw/rtl/slk_csr.sv =====
// ----------------------------------------------------------------------------
// slk_csr
// Configuration registers, write only.
// ----------------------------------------------------------------------------
module slk_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_write_data,
   output slk_pkg::cfg_type cfg
);

   slk_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms        <= 16'd100;
         cfg_ff.start_byte        <= 8'hAA;
         cfg_ff.read_command      <= 8'h01;
         cfg_ff.write_command     <= 8'h00;
         cfg_ff.read_reply_header <= 8'hBB;
         cfg_ff.ack_reply_header  <= 8'hEE;
         cfg_ff.write_ok_code     <= 8'h01;
      end else if (csr_write_enable) begin
         case (csr_index)
            slk_pkg::CsrTimeoutMs:    cfg_ff.timeout_ms        <= csr_write_data;
            slk_pkg::CsrStartByte:    cfg_ff.start_byte        <= csr_write_data[7:0];
            slk_pkg::CsrReadCommand:  cfg_ff.read_command      <= csr_write_data[7:0];
            slk_pkg::CsrWriteCommand: cfg_ff.write_command     <= csr_write_data[7:0];
            slk_pkg::CsrReadReplyHdr: cfg_ff.read_reply_header <= csr_write_data[7:0];
            slk_pkg::CsrAckReplyHdr:  cfg_ff.ack_reply_header  <= csr_write_data[7:0];
            slk_pkg::CsrWriteOkCode:  cfg_ff.write_ok_code     <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/slk_in_stage.sv =====
// ----------------------------------------------------------------------------
// slk_in_stage
// Input register for requests; holds a request until the control takes it.
// ----------------------------------------------------------------------------
module slk_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slk_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output slk_pkg::item_type item
);

   logic              valid_ff;
   slk_pkg::item_type item_ff;

   assign req_stall = valid_ff && !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/slk_ctrl.sv =====
// ----------------------------------------------------------------------------
// slk_ctrl
// Link sequencer: frames requests, checks reply bytes, counts timeout ticks
// and builds the result group for each request.
// ----------------------------------------------------------------------------
module slk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  slk_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  slk_pkg::item_type item,
   input  logic              grp_free,
   output logic              take,
   output slk_pkg::grp_type  grp
);

   localparam logic [3:0] PhIdle     = 4'd0;
   localparam logic [3:0] PhPayload  = 4'd1;
   localparam logic [3:0] PhWrHdr    = 4'd2;
   localparam logic [3:0] PhWrStatus = 4'd3;
   localparam logic [3:0] PhRdHdr    = 4'd4;
   localparam logic [3:0] PhRdErr    = 4'd5;
   localparam logic [3:0] PhRdLen    = 4'd6;
   localparam logic [3:0] PhRdData   = 4'd7;
   localparam logic [3:0] PhRdDrain  = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  expected_ff, expected_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  reply_len_ff, reply_len_in;
   logic [7:0]  reply_hdr_ff, reply_hdr_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  index_inc;
   logic        tick_active;

   assign take        = item_valid && grp_free;
   assign index_inc   = index_ff + 8'd1;
   assign tick_active = (phase_ff >= PhWrHdr) && (phase_ff <= PhRdDrain);

   always_comb begin
      phase_in     = phase_ff;
      expected_in  = expected_ff;
      index_in     = index_ff;
      reply_len_in = reply_len_ff;
      reply_hdr_in = reply_hdr_ff;
      elapsed_in   = elapsed_ff;
      grp.load     = 1'b0;
      grp.count    = '0;
      grp.entry    = '0;
      if (take) begin
         case (item.mode)
            slk_pkg::ModeStartRead,
            slk_pkg::ModeStartWrite: begin
               if (phase_ff != PhIdle ||
                   (item.mode == slk_pkg::ModeStartRead && item.count == 8'd0) ||
                   (item.mode == slk_pkg::ModeStartWrite &&
                    item.count > slk_pkg::MaxWriteBytes)) begin
                  grp.count    = 3'd1;
                  grp.entry[0] = slk_pkg::mk_status(slk_pkg::StBadRequest, 8'd0);
               end else begin
                  grp.count    = 3'd4;
                  grp.entry[0] = slk_pkg::mk_byte(slk_pkg::KindTransmit, cfg.start_byte);
                  grp.entry[1] = slk_pkg::mk_byte(slk_pkg::KindTransmit,
                     (item.mode == slk_pkg::ModeStartRead) ? cfg.read_command
                                                           : cfg.write_command);
                  grp.entry[2] = slk_pkg::mk_byte(slk_pkg::KindTransmit, item.address);
                  grp.entry[3] = slk_pkg::mk_byte(slk_pkg::KindTransmit, item.count);
                  expected_in  = item.count;
                  index_in     = 8'd0;
                  elapsed_in   = 16'd0;
                  if (item.mode == slk_pkg::ModeStartRead) begin
                     phase_in = PhRdHdr;
                  end else if (item.count == 8'd0) begin
                     phase_in = PhWrHdr;
                  end else begin
                     phase_in = PhPayload;
                  end
               end
            end
            slk_pkg::ModePayload: begin
               if (phase_ff == PhPayload) begin
                  grp.count    = 3'd1;
                  grp.entry[0] = slk_pkg::mk_byte(slk_pkg::KindTransmit, item.data);
                  index_in     = index_inc;
                  if (index_inc >= expected_ff) begin
                     elapsed_in = 16'd0;
                     phase_in   = PhWrHdr;
                  end
               end
            end
            slk_pkg::ModeReceived: begin
               elapsed_in = 16'd0;
               case (phase_ff)
                  PhWrHdr: begin
                     reply_hdr_in = item.data;
                     phase_in     = PhWrStatus;
                  end
                  PhWrStatus: begin
                     grp.count = 3'd1;
                     phase_in  = PhIdle;
                     if (reply_hdr_ff == cfg.ack_reply_header &&
                         item.data == cfg.write_ok_code) begin
                        grp.entry[0] = slk_pkg::mk_status(slk_pkg::StOk, item.data);
                     end else begin
                        grp.entry[0] = slk_pkg::mk_status(slk_pkg::StWrRejected, item.data);
                     end
                  end
                  PhRdHdr: begin
                     reply_hdr_in = item.data;
                     if (item.data == cfg.ack_reply_header) begin
                        phase_in = PhRdErr;
                     end else if (item.data == cfg.read_reply_header) begin
                        phase_in = PhRdLen;
                     end else begin
                        grp.count    = 3'd1;
                        grp.entry[0] = slk_pkg::mk_status(slk_pkg::StBadHeader, 8'd0);
                        phase_in     = PhIdle;
                     end
                  end
                  PhRdErr: begin
                     grp.count    = 3'd1;
                     grp.entry[0] = slk_pkg::mk_status(slk_pkg::StRdRefused, item.data);
                     phase_in     = PhIdle;
                  end
                  PhRdLen: begin
                     reply_len_in = item.data;
                     index_in     = 8'd0;
                     if (item.data == expected_ff) begin
                        phase_in = PhRdData;
                     end else if (item.data == 8'd0) begin
                        grp.count    = 3'd1;
                        grp.entry[0] = slk_pkg::mk_status(slk_pkg::StMismatch, 8'd0);
                        phase_in     = PhIdle;
                     end else begin
                        phase_in = PhRdDrain;
                     end
                  end
                  PhRdData: begin
                     grp.count    = 3'd1;
                     grp.entry[0] = slk_pkg::mk_byte(slk_pkg::KindReadData, item.data);
                     index_in     = index_inc;
                     if (index_inc == expected_ff) begin
                        grp.count    = 3'd2;
                        grp.entry[1] = slk_pkg::mk_status(slk_pkg::StOk, 8'd0);
                        phase_in     = PhIdle;
                     end
                  end
                  PhRdDrain: begin
                     index_in = index_inc;
                     if (index_inc == reply_len_ff) begin
                        grp.count    = 3'd1;
                        grp.entry[0] = slk_pkg::mk_status(slk_pkg::StMismatch, 8'd0);
                        phase_in     = PhIdle;
                     end
                  end
                  default: ;
               endcase
            end
            slk_pkg::ModeTick: begin
               if (tick_active) begin
                  if (elapsed_ff < cfg.timeout_ms) begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end else begin
                     grp.count = 3'd1;
                     phase_in  = PhIdle;
                     if (phase_ff == PhRdErr) begin
                        grp.entry[0] = slk_pkg::mk_status(slk_pkg::StRdRefused, 8'd0);
                     end else if (phase_ff == PhRdDrain) begin
                        grp.entry[0] = slk_pkg::mk_status(slk_pkg::StMismatch, 8'd0);
                     end else begin
                        grp.entry[0] = slk_pkg::mk_status(slk_pkg::StTimeout, 8'd0);
                     end
                  end
               end
            end
            default: ;
         endcase
         grp.load = (grp.count != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhIdle;
         expected_ff  <= 8'd0;
         index_ff     <= 8'd0;
         reply_len_ff <= 8'd0;
         reply_hdr_ff <= 8'd0;
         elapsed_ff   <= 16'd0;
      end else begin
         phase_ff     <= phase_in;
         expected_ff  <= expected_in;
         index_ff     <= index_in;
         reply_len_ff <= reply_len_in;
         reply_hdr_ff <= reply_hdr_in;
         elapsed_ff   <= elapsed_in;
      end
   end

endmodule

// ===== hw/rtl/slk_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// slk_rsp_buf
// Result register: holds one request's result group and hands it out one
// result per cycle while rsp_stall is low, marking the final one.
// ----------------------------------------------------------------------------
module slk_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  slk_pkg::grp_type grp,
   output logic             grp_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output slk_pkg::res_type rsp_res,
   output logic             rsp_last
);

   logic                                    valid_ff;
   logic [slk_pkg::GroupCountWidth-1:0]     count_ff;
   logic [slk_pkg::GroupIndexWidth-1:0]     index_ff;
   slk_pkg::res_type [slk_pkg::GroupDepth-1:0] entry_ff;
   logic                                    fire;
   logic                                    at_last;

   assign fire     = valid_ff && !rsp_stall;
   assign at_last  = ({1'b0, index_ff} + 1'b1) == count_ff;
   assign grp_free = !valid_ff || (fire && at_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
         count_ff <= '0;
      end else if (grp.load) begin
         valid_ff <= 1'b1;
         index_ff <= '0;
         count_ff <= grp.count;
      end else if (fire) begin
         valid_ff <= !at_last;
         index_ff <= index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (grp.load) begin
         entry_ff <= grp.entry;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = entry_ff[index_ff];
   assign rsp_last  = at_last;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (count_ff != '0 && count_ff <= slk_pkg::GroupDepth))
      else $error("result group count out of range");

   a_index_below_count: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, index_ff} < count_ff))
      else $error("result index past group end");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      grp.load |-> grp_free)
      else $error("result group overwritten before delivery");

   a_last_then_empty: assert property (@(posedge clock) disable iff (reset)
      (fire && at_last && !grp.load) |=> !valid_ff)
      else $error("result register still busy after final result");
`endif

endmodule

// ===== hw/rtl/sensor_uart_register_link_core.sv =====
// ----------------------------------------------------------------------------
// sensor_uart_register_link_core
// Host side of a sensor UART register protocol: frames read and write
// requests, forwards payload, checks replies and reports status.
//
//   channel   ports                         direction
//   request   req_valid/req_stall, req_*    in
//   result    rsp_valid/rsp_stall, rsp_*    out
//   config    csr_write_enable/index/data   in
//
// A request is registered, then processed into a result group of zero to
// four results, which drains one result per cycle while rsp_stall is low.
// One request per cycle when each yields at most one result and no stall is
// seen; a group of n results holds the next request until its last result goes.
// The first result is presented after the input register and the result register.
// Synchronous reset sets the link idle and restores register defaults.
// rsp_stall holds the result register, which in turn stalls requests.
// ----------------------------------------------------------------------------
module sensor_uart_register_link_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_address,
   input  logic [7:0]  req_count,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_device_status,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   slk_pkg::cfg_type  cfg;
   slk_pkg::item_type req_item;
   slk_pkg::item_type item;
   slk_pkg::grp_type  grp;
   slk_pkg::res_type  rsp_res;
   logic              item_valid;
   logic              take;
   logic              grp_free;

   assign req_item.mode    = req_mode;
   assign req_item.address = req_address;
   assign req_item.count   = req_count;
   assign req_item.data    = req_data;

   slk_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   slk_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   slk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .grp_free   (grp_free),
      .take       (take),
      .grp        (grp)
   );

   slk_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .grp       (grp),
      .grp_free  (grp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res),
      .rsp_last  (rsp_last)
   );

   assign rsp_kind          = rsp_res.kind;
   assign rsp_byte_value    = rsp_res.byte_value;
   assign rsp_status        = rsp_res.status;
   assign rsp_device_status = rsp_res.device_status;

endmodule

// ===== bench/sensor_uart_register_link_core_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_uart_register_link_core_tb
// Self-checking bench for the sensor UART register link. A cycle-level
// predictor tracks the link phase and registers. It turns every accepted
// request into the transmit, read data and status results that it should
// produce. The results are checked in order against the result channel.
// Directed corner cases come first. Then random read and write transactions
// with replies, timeouts and noise run under several register settings and
// with random idling on both channels.
// ----------------------------------------------------------------------------
module sensor_uart_register_link_core_tb;

   localparam logic [2:0] ModeUnused = 3'd7;
   localparam int WatchdogLimit = 2000;
   localparam int SettleCycles = 8;

   localparam logic [3:0] LinkIdle     = 4'd0;
   localparam logic [3:0] LinkPayload  = 4'd1;
   localparam logic [3:0] LinkWrHeader = 4'd2;
   localparam logic [3:0] LinkWrStatus = 4'd3;
   localparam logic [3:0] LinkRdHeader = 4'd4;
   localparam logic [3:0] LinkRdError  = 4'd5;
   localparam logic [3:0] LinkRdLength = 4'd6;
   localparam logic [3:0] LinkRdData   = 4'd7;
   localparam logic [3:0] LinkRdDrain  = 4'd8;

   typedef struct packed {
      slk_pkg::res_type r;
      logic             is_last;
   } expected_result_type;

   class link_scoreboard;
      slk_pkg::cfg_type    cfg;
      logic [3:0]          phase;
      logic                is_write;
      logic [7:0]          expected_count;
      logic [7:0]          byte_index;
      logic [7:0]          reply_length;
      logic [7:0]          reply_header;
      logic [15:0]         elapsed_ticks;
      expected_result_type pending[$];
      slk_pkg::res_type    batch[$];
      int                  mismatches;

      function void restore_defaults();
         cfg.timeout_ms        = 16'd100;
         cfg.start_byte        = 8'hAA;
         cfg.read_command      = 8'h01;
         cfg.write_command     = 8'h00;
         cfg.read_reply_header = 8'hBB;
         cfg.ack_reply_header  = 8'hEE;
         cfg.write_ok_code     = 8'h01;
         phase          = LinkIdle;
         is_write       = 1'b0;
         expected_count = 8'd0;
         byte_index     = 8'd0;
         reply_length   = 8'd0;
         reply_header   = 8'd0;
         elapsed_ticks  = 16'd0;
         mismatches     = 0;
         pending.delete();
      endfunction

      function void set_register(logic [2:0] index, logic [15:0] value);
         case (index)
            slk_pkg::CsrTimeoutMs:    cfg.timeout_ms        = value;
            slk_pkg::CsrStartByte:    cfg.start_byte        = value[7:0];
            slk_pkg::CsrReadCommand:  cfg.read_command      = value[7:0];
            slk_pkg::CsrWriteCommand: cfg.write_command     = value[7:0];
            slk_pkg::CsrReadReplyHdr: cfg.read_reply_header = value[7:0];
            slk_pkg::CsrAckReplyHdr:  cfg.ack_reply_header  = value[7:0];
            slk_pkg::CsrWriteOkCode:  cfg.write_ok_code     = value[7:0];
            default: ;
         endcase
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] value, logic [2:0] st,
                         logic [7:0] dev);
         slk_pkg::res_type r;
         r.kind          = kind;
         r.byte_value    = value;
         r.status        = st;
         r.device_status = dev;
         batch.push_back(r);
      endfunction

      function void conclude(logic [2:0] st, logic [7:0] dev);
         phase = LinkIdle;
         emit(slk_pkg::KindStatus, 8'd0, st, dev);
      endfunction

      function void send_frame(logic [7:0] cmd, logic [7:0] addr, logic [7:0] cnt);
         emit(slk_pkg::KindTransmit, cfg.start_byte, slk_pkg::StOk, 8'd0);
         emit(slk_pkg::KindTransmit, cmd, slk_pkg::StOk, 8'd0);
         emit(slk_pkg::KindTransmit, addr, slk_pkg::StOk, 8'd0);
         emit(slk_pkg::KindTransmit, cnt, slk_pkg::StOk, 8'd0);
      endfunction

      function void received_byte(logic [7:0] d);
         elapsed_ticks = 16'd0;
         case (phase)
            LinkWrHeader: begin
               reply_header = d;
               phase = LinkWrStatus;
            end
            LinkWrStatus: begin
               if (reply_header == cfg.ack_reply_header && d == cfg.write_ok_code)
                  conclude(slk_pkg::StOk, d);
               else
                  conclude(slk_pkg::StWrRejected, d);
            end
            LinkRdHeader: begin
               reply_header = d;
               if (d == cfg.ack_reply_header)
                  phase = LinkRdError;
               else if (d == cfg.read_reply_header)
                  phase = LinkRdLength;
               else
                  conclude(slk_pkg::StBadHeader, 8'd0);
            end
            LinkRdError: conclude(slk_pkg::StRdRefused, d);
            LinkRdLength: begin
               reply_length = d;
               byte_index = 8'd0;
               if (d == expected_count)
                  phase = LinkRdData;
               else if (d == 8'd0)
                  conclude(slk_pkg::StMismatch, 8'd0);
               else
                  phase = LinkRdDrain;
            end
            LinkRdData: begin
               emit(slk_pkg::KindReadData, d, slk_pkg::StOk, 8'd0);
               byte_index = byte_index + 8'd1;
               if (byte_index == expected_count)
                  conclude(slk_pkg::StOk, 8'd0);
            end
            LinkRdDrain: begin
               byte_index = byte_index + 8'd1;
               if (byte_index == reply_length)
                  conclude(slk_pkg::StMismatch, 8'd0);
            end
            default: ;
         endcase
      endfunction

      function void tick();
         if (phase == LinkIdle || phase == LinkPayload || phase > LinkRdDrain)
            return;
         if (elapsed_ticks < cfg.timeout_ms) begin
            elapsed_ticks = elapsed_ticks + 16'd1;
            return;
         end
         if (phase == LinkRdError)
            conclude(slk_pkg::StRdRefused, 8'd0);
         else if (phase == LinkRdDrain)
            conclude(slk_pkg::StMismatch, 8'd0);
         else
            conclude(slk_pkg::StTimeout, 8'd0);
      endfunction

      function void note_request(slk_pkg::item_type it);
         expected_result_type e;
         batch.delete();
         case (it.mode)
            slk_pkg::ModeStartRead: begin
               if (phase != LinkIdle || it.count == 8'd0) begin
                  emit(slk_pkg::KindStatus, 8'd0, slk_pkg::StBadRequest, 8'd0);
               end else begin
                  send_frame(cfg.read_command, it.address, it.count);
                  is_write       = 1'b0;
                  expected_count = it.count;
                  byte_index     = 8'd0;
                  elapsed_ticks  = 16'd0;
                  phase          = LinkRdHeader;
               end
            end
            slk_pkg::ModeStartWrite: begin
               if (phase != LinkIdle || it.count > slk_pkg::MaxWriteBytes) begin
                  emit(slk_pkg::KindStatus, 8'd0, slk_pkg::StBadRequest, 8'd0);
               end else begin
                  send_frame(cfg.write_command, it.address, it.count);
                  is_write       = 1'b1;
                  expected_count = it.count;
                  byte_index     = 8'd0;
                  elapsed_ticks  = 16'd0;
                  phase          = (it.count == 8'd0) ? LinkWrHeader : LinkPayload;
               end
            end
            slk_pkg::ModePayload: begin
               if (phase == LinkPayload) begin
                  emit(slk_pkg::KindTransmit, it.data, slk_pkg::StOk, 8'd0);
                  byte_index = byte_index + 8'd1;
                  if (byte_index >= expected_count) begin
                     elapsed_ticks = 16'd0;
                     phase = LinkWrHeader;
                  end
               end
            end
            slk_pkg::ModeReceived: received_byte(it.data);
            slk_pkg::ModeTick:     tick();
            default: ;
         endcase
         foreach (batch[i]) begin
            e.r = batch[i];
            e.is_last = (i == batch.size() - 1);
            pending.push_back(e);
         end
      endfunction

      // a request that moves an open transaction toward idle
      function slk_pkg::item_type closing_item();
         slk_pkg::item_type it;
         logic [7:0] d;
         it.mode    = slk_pkg::ModeReceived;
         it.address = 8'($urandom);
         it.count   = 8'($urandom);
         it.data    = 8'($urandom);
         case (phase)
            LinkPayload:  it.mode = slk_pkg::ModePayload;
            LinkWrHeader: it.data = cfg.ack_reply_header;
            LinkWrStatus: it.data = cfg.write_ok_code;
            LinkRdHeader: begin
               d = cfg.read_reply_header + 8'd1;
               while (d == cfg.ack_reply_header || d == cfg.read_reply_header)
                  d = d + 8'd1;
               it.data = d;
            end
            LinkRdLength: it.data = 8'd0;
            default: ;
         endcase
         return it;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_result(slk_pkg::res_type got, logic is_last);
         expected_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("result %h with nothing expected", got));
            return;
         end
         want = pending.pop_front();
         compare_field("kind", 16'(got.kind), 16'(want.r.kind));
         compare_field("byte_value", 16'(got.byte_value), 16'(want.r.byte_value));
         compare_field("status", 16'(got.status), 16'(want.r.status));
         compare_field("device_status", 16'(got.device_status),
                       16'(want.r.device_status));
         compare_field("last", 16'(is_last), 16'(want.is_last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = slk_pkg::ModeTick;
   logic [7:0]  req_address = 8'd0;
   logic [7:0]  req_count = 8'd0;
   logic [7:0]  req_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_byte_value;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_device_status;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = slk_pkg::CsrTimeoutMs;
   logic [15:0] csr_write_data = 16'd0;

   link_scoreboard sb;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_done = 0;
   int quiet_cycles = 0;

   sensor_uart_register_link_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_address(req_address),
      .req_count(req_count),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_byte_value(rsp_byte_value),
      .rsp_status(rsp_status),
      .rsp_device_status(rsp_device_status),
      .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_kind, rsp_byte_value, rsp_status, rsp_device_status},
                         rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("watchdog: no traffic for %0d cycles", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task send_request(input logic [2:0] mode, input logic [7:0] addr,
                     input logic [7:0] cnt, input logic [7:0] d);
      slk_pkg::item_type it;
      it.mode    = mode;
      it.address = addr;
      it.count   = cnt;
      it.data    = d;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_address <= addr;
      req_count   <= cnt;
      req_data    <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(it);
      items_done++;
   endtask

   task write_csr(input logic [2:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_register(index, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // close any open transaction, then wait for the link to drain
   task settle();
      slk_pkg::item_type it;
      while (sb.phase != LinkIdle) begin
         it = sb.closing_item();
         send_request(it.mode, it.address, it.count, it.data);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task maybe_ticks();
      if ($urandom_range(99) < 20)
         repeat ($urandom_range(1, 4))
            send_request(slk_pkg::ModeTick, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task random_write();
      int r;
      logic [7:0] cnt;
      r = $urandom_range(99);
      if (r < 86)
         cnt = 8'($urandom_range(0, 6));
      else if (r < 94)
         cnt = 8'($urandom_range(129, 255));
      else
         cnt = 8'($urandom_range(7, 24));
      send_request(slk_pkg::ModeStartWrite, 8'($urandom), cnt, 8'($urandom));
      if (cnt > slk_pkg::MaxWriteBytes)
         return;
      repeat (cnt) begin
         if ($urandom_range(99) < 10)
            send_request($urandom_range(1) ? slk_pkg::ModeReceived : slk_pkg::ModeTick,
                         8'($urandom), 8'($urandom), 8'($urandom));
         send_request(slk_pkg::ModePayload, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      maybe_ticks();
      send_request(slk_pkg::ModeReceived, 8'($urandom), 8'($urandom),
                   ($urandom_range(99) < 85) ? sb.cfg.ack_reply_header : 8'($urandom));
      maybe_ticks();
      // sometimes leave the acknowledgement open
      if ($urandom_range(99) < 5)
         return;
      send_request(slk_pkg::ModeReceived, 8'($urandom), 8'($urandom),
                   ($urandom_range(99) < 80) ? sb.cfg.write_ok_code : 8'($urandom));
   endtask

   task random_read();
      int r;
      logic [7:0] cnt;
      logic [7:0] hdr;
      logic [7:0] len;
      r = $urandom_range(99);
      if (r < 5)
         cnt = 8'd0;
      else if (r < 85)
         cnt = 8'($urandom_range(1, 6));
      else if (r < 99)
         cnt = 8'($urandom_range(7, 16));
      else
         cnt = 8'd255;
      send_request(slk_pkg::ModeStartRead, 8'($urandom), cnt, 8'($urandom));
      if (cnt == 8'd0)
         return;
      maybe_ticks();
      r = $urandom_range(99);
      if (r < 70)
         hdr = sb.cfg.read_reply_header;
      else if (r < 85)
         hdr = sb.cfg.ack_reply_header;
      else
         hdr = 8'($urandom);
      send_request(slk_pkg::ModeReceived, 8'($urandom), 8'($urandom), hdr);
      if (hdr == sb.cfg.ack_reply_header) begin
         maybe_ticks();
         send_request(slk_pkg::ModeReceived, 8'($urandom), 8'($urandom), 8'($urandom));
         return;
      end
      if (hdr != sb.cfg.read_reply_header)
         return;
      maybe_ticks();
      r = $urandom_range(99);
      if (r < 75 && cnt != 8'd255)
         len = cnt;
      else if (r < 85)
         len = 8'd0;
      else
         len = 8'($urandom_range(1, 8));
      send_request(slk_pkg::ModeReceived, 8'($urandom), 8'($urandom), len);
      repeat (len) begin
         if ($urandom_range(99) < 15)
            maybe_ticks();
         send_request(slk_pkg::ModeReceived, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task run_random(input int target);
      int goal;
      int r;
      goal = items_done + target;
      while (items_done < goal) begin
         r = $urandom_range(99);
         if (r < 40)
            random_write();
         else if (r < 85)
            random_read();
         else
            repeat ($urandom_range(1, 3))
               send_request(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                            8'($urandom));
      end
      settle();
   endtask

   initial begin
      sb = new;
      sb.restore_defaults();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners, short timeout
      write_csr(slk_pkg::CsrTimeoutMs, 16'd1);
      send_request(slk_pkg::ModeStartRead, 8'h00, 8'h00, 8'h00);
      send_request(slk_pkg::ModeStartWrite, 8'hFF, 8'hFF, 8'hFF);
      send_request(ModeUnused, 8'hFF, 8'hFF, 8'hFF);
      send_request(slk_pkg::ModePayload, 8'h00, 8'h00, 8'h5A);
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'hEE);
      send_request(slk_pkg::ModeTick, 8'h00, 8'h00, 8'h00);
      send_request(slk_pkg::ModeStartWrite, 8'h00, 8'd1, 8'h00);
      send_request(slk_pkg::ModeStartRead, 8'h12, 8'd4, 8'h00);
      send_request(slk_pkg::ModePayload, 8'h00, 8'h00, 8'hFF);
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'hEE);
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'h01);
      send_request(slk_pkg::ModeStartRead, 8'h5A, 8'd2, 8'h00);
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'hEE);
      send_request(slk_pkg::ModeTick, 8'h00, 8'h00, 8'h00);
      send_request(slk_pkg::ModeTick, 8'h00, 8'h00, 8'h00);
      send_request(slk_pkg::ModeStartRead, 8'hA5, 8'd1, 8'h00);
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'hBB);
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'h00);
      send_request(slk_pkg::ModeStartRead, 8'h33, 8'd1, 8'h00);
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'h42);
      send_request(slk_pkg::ModeStartWrite, 8'h44, 8'd0, 8'h00);
      send_request(slk_pkg::ModeTick, 8'h00, 8'h00, 8'h00);
      send_request(slk_pkg::ModeTick, 8'h00, 8'h00, 8'h00);
      // longest accepted write
      send_request(slk_pkg::ModeStartWrite, 8'h7F, slk_pkg::MaxWriteBytes, 8'h00);
      repeat (slk_pkg::MaxWriteBytes)
         send_request(slk_pkg::ModePayload, 8'h00, 8'h00, 8'($urandom));
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'hEE);
      send_request(slk_pkg::ModeReceived, 8'h00, 8'h00, 8'h01);
      settle();

      // low extremes, no idling
      write_csr(slk_pkg::CsrTimeoutMs, 16'd0);
      write_csr(slk_pkg::CsrStartByte, 16'h0000);
      write_csr(slk_pkg::CsrReadCommand, 16'hFFFF);
      write_csr(slk_pkg::CsrWriteCommand, 16'h0000);
      write_csr(slk_pkg::CsrReadReplyHdr, 16'h00FF);
      write_csr(slk_pkg::CsrAckReplyHdr, 16'hFF00);
      write_csr(slk_pkg::CsrWriteOkCode, 16'h00FF);
      run_random(18);

      // sender idle
      write_csr(slk_pkg::CsrTimeoutMs, 16'd2);
      write_csr(slk_pkg::CsrStartByte, 16'h00A5);
      write_csr(slk_pkg::CsrReadCommand, 16'h005A);
      write_csr(slk_pkg::CsrWriteCommand, 16'h003C);
      write_csr(slk_pkg::CsrReadReplyHdr, 16'($urandom));
      write_csr(slk_pkg::CsrAckReplyHdr, 16'($urandom));
      write_csr(slk_pkg::CsrWriteOkCode, 16'($urandom));
      idle_pct = 72;
      run_random(18);

      // high extremes, ack and read headers equal, receiver stalls
      write_csr(slk_pkg::CsrTimeoutMs, 16'hFFFF);
      write_csr(slk_pkg::CsrStartByte, 16'h00FF);
      write_csr(slk_pkg::CsrReadCommand, 16'h0000);
      write_csr(slk_pkg::CsrWriteCommand, 16'hFFFF);
      write_csr(slk_pkg::CsrReadReplyHdr, 16'h0077);
      write_csr(slk_pkg::CsrAckReplyHdr, 16'h0077);
      write_csr(slk_pkg::CsrWriteOkCode, 16'h0000);
      idle_pct = 0;
      stall_pct = 72;
      run_random(18);

      // both sides idle
      write_csr(slk_pkg::CsrTimeoutMs, 16'd1);
      write_csr(slk_pkg::CsrStartByte, 16'($urandom));
      write_csr(slk_pkg::CsrReadCommand, 16'($urandom));
      write_csr(slk_pkg::CsrWriteCommand, 16'($urandom));
      write_csr(slk_pkg::CsrReadReplyHdr, 16'($urandom));
      write_csr(slk_pkg::CsrAckReplyHdr, 16'($urandom));
      write_csr(slk_pkg::CsrWriteOkCode, 16'($urandom));
      idle_pct = 24;
      stall_pct = 24;
      run_random(18);

      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      if (sb.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
